// ===== rtl/pmg_pkg.sv =====
// shared types, register indexes and widths for the point-mass gravity source term
package pmg_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int H_W = 38;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAV      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_EN = 3'd5;

  typedef struct packed {
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic [30:0]        density;
    logic signed [31:0] flux_x_lo;
    logic signed [31:0] flux_x_hi;
    logic signed [31:0] flux_y_lo;
    logic signed [31:0] flux_y_hi;
    logic signed [31:0] flux_z_lo;
    logic signed [31:0] flux_z_hi;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] mom_x_delta;
    logic signed [31:0] mom_y_delta;
    logic signed [31:0] mom_z_delta;
    logic signed [31:0] energy_delta;
  } incr_t;

  // side data riding along the square root
  typedef struct packed {
    logic             zero;
    logic [2:0][31:0] mag;
  } sside_t;

  // side data riding along the gm / r^2 divider
  typedef struct packed {
    logic [30:0]      rho;
    logic [2:0][32:0] s;
    logic [2:0]       dneg;
    logic             sat;
  } hside_t;

  typedef struct packed {
    logic [H_W-1:0] h;
    hside_t         side;
  } hres_t;

endpackage

// ===== rtl/pmg_isqrt.sv =====
// pipelined integer square root of a 64-bit word, one result bit per stage
module pmg_isqrt #(
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [63:0]   v,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [31:0]   r,
  output logic [TW-1:0] out_tag
);

  localparam int STAGES = 32;

  logic [STAGES-1:0] val_r;
  logic [63:0]       res_r [STAGES];
  logic [63:0]       v_r   [STAGES-1];
  logic [TW-1:0]     tag_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]   v_in, res_in, v_nx, res_nx;
    logic [TW-1:0] tag_in;
    logic          val_in;

    if (k == 0) begin : g_head
      assign v_in   = v;
      assign res_in = '0;
      assign tag_in = tag;
      assign val_in = in_valid;
    end else begin : g_body
      assign v_in   = v_r[k-1];
      assign res_in = res_r[k-1];
      assign tag_in = tag_r[k-1];
      assign val_in = val_r[k-1];
    end

    always_comb begin
      if (v_in >= res_in + BIT) begin
        v_nx   = v_in - (res_in + BIT);
        res_nx = (res_in >> 1) + BIT;
      end else begin
        v_nx   = v_in;
        res_nx = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      res_r[k] <= res_nx;
      tag_r[k] <= tag_in;
    end

    if (k < STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        v_r[k] <= v_nx;
      end
    end
  end

  assign out_valid = val_r[STAGES-1];
  assign r         = res_r[STAGES-1][31:0];
  assign out_tag   = tag_r[STAGES-1];

endmodule

// ===== rtl/pmg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, lanes share a divisor
module pmg_div #(
  parameter int LANES = 1,
  parameter int DW    = 32,
  parameter int QW    = 8,
  parameter int TW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [DW-1:0]              den,
  input  logic [LANES-1:0][DW-1:0]   rem0,
  input  logic [LANES-1:0][QW-1:0]   num,
  input  logic [TW-1:0]              tag,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quot,
  output logic [TW-1:0]              out_tag
);

  logic [QW-1:0]                val_r;
  logic [LANES-1:0][DW-1:0]     rem_r [QW];
  // remaining numerator bits shift out at the top, quotient bits shift in below
  logic [LANES-1:0][QW-1:0]     num_r [QW];
  logic [DW-1:0]                den_r [QW-1];
  logic [TW-1:0]                tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_in, rem_nx;
    logic [LANES-1:0][QW-1:0] num_in, num_nx;
    logic [DW-1:0]            den_in;
    logic [TW-1:0]            tag_in;
    logic                     val_in;

    if (k == 0) begin : g_head
      assign rem_in = rem0;
      assign num_in = num;
      assign den_in = den;
      assign tag_in = tag;
      assign val_in = in_valid;
    end else begin : g_body
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign tag_in = tag_r[k-1];
      assign val_in = val_r[k-1];
    end

    always_comb begin
      logic [DW:0] trial;
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_in[l], num_in[l][QW-1]};
        if (trial >= {1'b0, den_in}) begin
          rem_nx[l] = DW'(trial - {1'b0, den_in});
          num_nx[l] = {num_in[l][QW-2:0], 1'b1};
        end else begin
          rem_nx[l] = trial[DW-1:0];
          num_nx[l] = {num_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val_r[k] <= 1'b0;
      end else begin
        val_r[k] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nx;
      num_r[k] <= num_nx;
      tag_r[k] <= tag_in;
    end

    if (k < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        den_r[k] <= den_in;
      end
    end
  end

  assign out_valid = val_r[QW-1];
  assign quot      = num_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

// ===== rtl/pmg_dly.sv =====
// fixed-depth delay line with a valid bit
module pmg_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] din,
  output logic         out_valid,
  output logic [W-1:0] dout
);

  logic [D-1:0] val_r;
  logic [W-1:0] data_r [D];

  always_ff @(posedge clk) begin
    if (rst) begin
      val_r <= '0;
    end else begin
      val_r[0] <= in_valid;
      for (int i = 1; i < D; i++) val_r[i] <= val_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    data_r[0] <= din;
    for (int i = 1; i < D; i++) data_r[i] <= data_r[i-1];
  end

  assign out_valid = val_r[D-1];
  assign dout      = data_r[D-1];

endmodule

// ===== rtl/point_mass_gravity_source_term.sv =====
// top level of the point-mass gravity source term pipeline
// latency from accept to the done strobe grows with FRACTION_BITS (Q16.16 by default)
// throughput: one cell word per cycle; busy stays low, start is always taken
// latency is set by the bit-per-stage square root (32) and the u divider (F+1)
// synchronous active-high reset clears the valid bits and config (energy on)
// results are shown for one cycle on done; the receiver cannot stall
module point_mass_gravity_source_term #(
  parameter int FRACTION_BITS = pmg_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pmg_pkg::cell_t                  cell_word,
  output logic                            done,
  output pmg_pkg::incr_t                  incr,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  localparam int F      = FRACTION_BITS;
  localparam int H_W    = pmg_pkg::H_W;
  localparam int NUM_W  = 31 + 2 * F;       // gm << 2F
  localparam int HREM_W = NUM_W - H_W;      // numerator bits above the saturation point
  localparam int UQ_W   = F + 1;            // |d|/r is at most one
  localparam int PH_W   = H_W + UQ_W;
  localparam int SH_W   = PH_W - F;
  localparam int H_DLY  = F - 5;            // delay depth that lines h up with the later u
  localparam int STW    = $bits(pmg_pkg::sside_t);
  localparam int HTW    = $bits(pmg_pkg::hside_t);
  localparam int HRW    = $bits(pmg_pkg::hres_t);

  // ---------------- configuration registers ----------------
  logic [30:0]        time_step;
  logic [30:0]        grav_strength;
  logic signed [31:0] pos [3];
  logic               energy_enable;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step     <= '0;
      grav_strength <= '0;
      pos[0]        <= '0;
      pos[1]        <= '0;
      pos[2]        <= '0;
      energy_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmg_pkg::REG_TIME_STEP: time_step     <= cfg_data[30:0];
        pmg_pkg::REG_GRAV:      grav_strength <= cfg_data[30:0];
        pmg_pkg::REG_POS_X:     pos[0]        <= cfg_data;
        pmg_pkg::REG_POS_Y:     pos[1]        <= cfg_data;
        pmg_pkg::REG_POS_Z:     pos[2]        <= cfg_data;
        pmg_pkg::REG_ENERGY_EN: energy_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // gm scaled by 2^2F, split at the saturation point of h
  logic [NUM_W-1:0]  num;
  logic [HREM_W-1:0] num_hi;
  assign num    = {grav_strength, {(2 * F){1'b0}}};
  assign num_hi = num[NUM_W-1:H_W];

  // ---------------- input lanes ----------------
  logic signed [31:0] cc [3];
  logic signed [31:0] flo [3];
  logic signed [31:0] fhi [3];

  assign cc[0]  = cell_word.cell_x;
  assign cc[1]  = cell_word.cell_y;
  assign cc[2]  = cell_word.cell_z;
  assign flo[0] = cell_word.flux_x_lo;
  assign fhi[0] = cell_word.flux_x_hi;
  assign flo[1] = cell_word.flux_y_lo;
  assign fhi[1] = cell_word.flux_y_hi;
  assign flo[2] = cell_word.flux_z_lo;
  assign fhi[2] = cell_word.flux_z_hi;

  // ---------------- stage 1: saturated offsets, magnitudes, flux sums ----------------
  logic             v1;
  logic [2:0][31:0] mag1;
  logic [2:0]       dneg1;
  logic [2:0][32:0] s1;
  logic [30:0]      rho1;

  logic [2:0][31:0] mag1_next;
  logic [2:0]       dneg1_next;
  logic [2:0][32:0] s1_next;

  always_comb begin
    logic [32:0] diff;
    logic [31:0] dsat;
    for (int d = 0; d < 3; d++) begin
      diff = {cc[d][31], cc[d]} - {pos[d][31], pos[d]};
      if (diff[32] != diff[31]) begin
        // offset overflow clamps to the signed word range
        dsat = diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        dsat = diff[31:0];
      end
      dneg1_next[d] = dsat[31];
      mag1_next[d]  = dsat[31] ? (~dsat + 32'd1) : dsat;
      s1_next[d]    = {flo[d][31], flo[d]} + {fhi[d][31], fhi[d]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mag1  <= mag1_next;
    dneg1 <= dneg1_next;
    s1    <= s1_next;
    rho1  <= cell_word.density;
  end

  // ---------------- stage 2: squares ----------------
  logic             v2;
  logic [2:0][63:0] sq2;
  logic [2:0][31:0] mag2;
  logic [2:0]       dneg2;
  logic [2:0][32:0] s2;
  logic [30:0]      rho2;
  logic             zero2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) sq2[d] <= mag1[d] * mag1[d];
    mag2  <= mag1;
    dneg2 <= dneg1;
    s2    <= s1;
    rho2  <= rho1;
    zero2 <= (mag1[0] == '0) && (mag1[1] == '0) && (mag1[2] == '0);
  end

  // ---------------- stage 3: r^2 and h saturation test ----------------
  logic             v3;
  logic [63:0]      r2_3;
  pmg_pkg::sside_t  sside3;
  pmg_pkg::hside_t  hside3;
  logic [63:0]      r2_sum;

  assign r2_sum = sq2[0] + sq2[1] + sq2[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    r2_3 <= r2_sum;
    // quotient reaches 2^38 exactly when the numerator top part covers r^2
    hside3.sat  <= {{(64 - HREM_W){1'b0}}, num_hi} >= r2_sum;
    sside3.zero <= zero2;
    sside3.mag  <= mag2;
    hside3.rho  <= rho2;
    hside3.s    <= s2;
    hside3.dneg <= dneg2;
  end

  // ---------------- r = isqrt(r^2) ----------------
  logic            vs;
  logic [31:0]     r_s;
  pmg_pkg::sside_t sside_s;

  pmg_isqrt #(.TW(STW)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .v         (r2_3),
    .tag       (sside3),
    .out_valid (vs),
    .r         (r_s),
    .out_tag   (sside_s)
  );

  // ---------------- u = |d| * 2^F / r, three lanes ----------------
  logic [2:0][31:0]   urem0;
  logic [2:0][UQ_W-1:0] unum;
  logic               vu;
  logic [2:0][UQ_W-1:0] uq;
  logic               zero_u;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      // quotient fits F+1 bits, so start from |d| >> 1 which is below r
      urem0[d] = {1'b0, sside_s.mag[d][31:1]};
      unum[d]  = {sside_s.mag[d][0], {F{1'b0}}};
    end
  end

  pmg_div #(.LANES(3), .DW(32), .QW(UQ_W), .TW(1)) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .den       (r_s),
    .rem0      (urem0),
    .num       (unum),
    .tag       (sside_s.zero),
    .out_valid (vu),
    .quot      (uq),
    .out_tag   (zero_u)
  );

  // ---------------- h = gm * 2^2F / r^2, in parallel ----------------
  logic [0:0][63:0]    hrem0;
  logic [0:0][H_W-1:0] hnum;
  logic                vh;
  logic [0:0][H_W-1:0] hq;
  pmg_pkg::hside_t     hside_h;
  pmg_pkg::hres_t      hres_h;
  pmg_pkg::hres_t      hres_a;
  logic                vh_a;

  assign hrem0[0] = {{(64 - HREM_W){1'b0}}, num_hi};
  assign hnum[0]  = num[H_W-1:0];

  pmg_div #(.LANES(1), .DW(64), .QW(H_W), .TW(HTW)) u_hdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .den       (r2_3),
    .rem0      (hrem0),
    .num       (hnum),
    .tag       (hside3),
    .out_valid (vh),
    .quot      (hq),
    .out_tag   (hside_h)
  );

  assign hres_h.h    = hq[0];
  assign hres_h.side = hside_h;

  // line h up with the longer sqrt + u path
  pmg_dly #(.W(HRW), .D(H_DLY)) u_hdly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vh),
    .din       (hres_h),
    .out_valid (vh_a),
    .dout      (hres_a)
  );

  // ---------------- A1: h * u, dt * rho ----------------
  logic                 va1;
  logic [2:0][PH_W-1:0] prod1;
  logic [61:0]          p1;
  logic [2:0][32:0]     s_a1;
  logic [2:0]           dneg_a1;
  logic                 zero_a1;
  logic [H_W-1:0]       hh;

  assign hh = hres_a.side.sat ? {H_W{1'b1}} : hres_a.h;

  always_ff @(posedge clk) begin
    if (rst) begin
      va1 <= 1'b0;
    end else begin
      va1 <= vu && vh_a;
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) prod1[d] <= hh * uq[d];
    p1      <= time_step * hres_a.side.rho;
    s_a1    <= hres_a.side.s;
    dneg_a1 <= hres_a.side.dneg;
    zero_a1 <= zero_u;
  end

  // ---------------- A2: acceleration magnitude and sign ----------------
  logic             va2;
  logic [2:0][30:0] m2;
  logic [2:0]       aneg2;
  logic [61:0]      p2;
  logic [2:0][32:0] s_a2;
  logic [2:0][30:0] m2_next;
  logic [2:0]       aneg2_next;

  always_comb begin
    logic [SH_W-1:0] shp;
    for (int d = 0; d < 3; d++) begin
      shp = prod1[d][PH_W-1:F];
      if (zero_a1) begin
        m2_next[d] = '0;          // coincident point: no pull
      end else if (|shp[SH_W-1:31]) begin
        m2_next[d] = 31'h7fff_ffff;
      end else begin
        m2_next[d] = shp[30:0];
      end
      // pull points back toward the mass
      aneg2_next[d] = (m2_next[d] != '0) && !dneg_a1[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va2 <= 1'b0;
    end else begin
      va2 <= va1;
    end
  end

  always_ff @(posedge clk) begin
    m2    <= m2_next;
    aneg2 <= aneg2_next;
    p2    <= p1;
    s_a2  <= s_a1;
  end

  // ---------------- A3: partial products ----------------
  logic             va3;
  logic [2:0][63:0] mlo3;
  logic [2:0][63:0] mhi3;
  logic [2:0][63:0] t3;
  logic [2:0]       aneg3;
  logic [2:0]       eneg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      va3 <= 1'b0;
    end else begin
      va3 <= va2;
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] smag;
    logic [63:0] tp;
    for (int d = 0; d < 3; d++) begin
      smag     = s_a2[d][32] ? (~s_a2[d] + 33'd1) : s_a2[d];
      tp       = m2[d] * smag;
      t3[d]    <= tp >> F;
      mlo3[d]  <= p2[31:0] * m2[d];
      mhi3[d]  <= {2'b00, p2[61:32]} * m2[d];
      eneg3[d] <= aneg2[d] ^ s_a2[d][32];
    end
    aneg3 <= aneg2;
  end

  // saturate a shifted product magnitude and apply its sign
  function automatic logic [31:0] sat_word(input logic [95:0] q, input logic neg);
    logic [95:0] lim;
    logic [31:0] val;
    lim = neg ? 96'h8000_0000 : 96'h7fff_ffff;
    val = (q > lim) ? lim[31:0] : q[31:0];
    return neg ? (~val + 32'd1) : val;
  endfunction

  // ---------------- A4: momentum words, energy sum ----------------
  logic             va4;
  logic [2:0][31:0] mom4;
  logic [63:0]      sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      va4 <= 1'b0;
    end else begin
      va4 <= va3;
    end
  end

  always_ff @(posedge clk) begin
    logic [95:0] mfull;
    logic [63:0] acc;
    acc = '0;
    for (int d = 0; d < 3; d++) begin
      mfull   = {32'd0, mlo3[d]} + {mhi3[d], 32'd0};
      mom4[d] <= sat_word(mfull >> (2 * F), aneg3[d]);
      acc     = acc + (eneg3[d] ? (~t3[d] + 64'd1) : t3[d]);
    end
    sum4 <= acc;
  end

  // ---------------- A5: energy sum magnitude ----------------
  logic             va5;
  logic [63:0]      smag5;
  logic             sneg5;
  logic [2:0][31:0] mom5;

  always_ff @(posedge clk) begin
    if (rst) begin
      va5 <= 1'b0;
    end else begin
      va5 <= va4;
    end
  end

  always_ff @(posedge clk) begin
    sneg5 <= sum4[63];
    smag5 <= sum4[63] ? (~sum4 + 64'd1) : sum4;
    mom5  <= mom4;
  end

  // ---------------- A6: dt partial products ----------------
  logic             va6;
  logic [63:0]      elo6;
  logic [63:0]      ehi6;
  logic             sneg6;
  logic [2:0][31:0] mom6;

  always_ff @(posedge clk) begin
    if (rst) begin
      va6 <= 1'b0;
    end else begin
      va6 <= va5;
    end
  end

  always_ff @(posedge clk) begin
    elo6  <= smag5[31:0] * time_step;
    ehi6  <= smag5[63:32] * time_step;
    sneg6 <= sneg5;
    mom6  <= mom5;
  end

  // ---------------- A7: output word ----------------
  logic [95:0] efull;
  assign efull = {32'd0, elo6} + {ehi6, 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= va6;
    end
  end

  always_ff @(posedge clk) begin
    incr.mom_x_delta  <= mom6[0];
    incr.mom_y_delta  <= mom6[1];
    incr.mom_z_delta  <= mom6[2];
    // the half factor is the extra shift by one
    incr.energy_delta <= energy_enable ? sat_word(efull >> (F + 1), sneg6) : 32'd0;
  end

endmodule

// ===== rtl/pmg_checker.sv =====
// port-level checks for the gravity source term, bound to the top level
module pmg_checker #(
  parameter int FRACTION_BITS = pmg_pkg::FRACTION_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_valid,
  input logic cfg_ready
);

  localparam int LAT = 43 + FRACTION_BITS;

  // every accepted word comes out a fixed time later
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted word did not complete on time");

  // no result without a matching accept
  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted word");

  // reset flushes the pipeline
  a_rst_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // config writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind point_mass_gravity_source_term pmg_checker #(.FRACTION_BITS(FRACTION_BITS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
